[hdl/salwc_pkg.sv]
// Shared types, constants and width helpers for the set-associative LRU
// write-back cache tag store. No dependencies.
package salwc_pkg;

    localparam int DEF_MAX_SETS = 64;
    localparam int DEF_MAX_WAYS = 8;

    localparam int BLK_W      = 32;
    localparam int WAYS_REG_W = 4;
    localparam int SETS_REG_W = 7;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [WAYS_REG_W-1:0] WAYS_RST = 4'd8;
    localparam logic [SETS_REG_W-1:0] SETS_RST = 7'd64;

    // register select bit, paddr[2]
    localparam logic REG_WAYS = 1'b0;
    localparam logic REG_SETS = 1'b1;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_WB   = 1'b1;

    // bits needed to index n entries
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // bits needed to hold a count from 0 to n
    function automatic int cnt_w(input int n);
        return $clog2(n + 1);
    endfunction

    // meta row: per way {valid, dirty, age}, fill count on top
    function automatic int meta_w(input int max_ways);
        return max_ways * (2 + idx_w(max_ways)) + cnt_w(max_ways);
    endfunction

    typedef struct packed {
        logic             hit;
        logic             wb;
        logic [BLK_W-1:0] wb_block;
    } upd_t;

endpackage

[hdl/salwc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on salwc_pkg for default sizes.
module salwc_ram #(
    parameter int WIDTH = salwc_pkg::BLK_W,
    parameter int DEPTH = salwc_pkg::DEF_MAX_SETS
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [salwc_pkg::idx_w(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [salwc_pkg::idx_w(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/salwc_set_idx.sv]
// Set index unit: (block_id / ways) mod sets, one quotient bit per cycle,
// the modulo reduced on the fly from the quotient bits. Depends on salwc_pkg.
module salwc_set_idx #(
    parameter int MAX_WAYS = salwc_pkg::DEF_MAX_WAYS,
    parameter int MAX_SETS = salwc_pkg::DEF_MAX_SETS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [salwc_pkg::BLK_W-1:0]             block_id,
    input  logic [salwc_pkg::cnt_w(MAX_WAYS)-1:0]   ways,
    input  logic [salwc_pkg::cnt_w(MAX_SETS)-1:0]   sets,
    output logic                                    done,
    output logic [salwc_pkg::idx_w(MAX_SETS)-1:0]   set_idx
);

    localparam int BW  = salwc_pkg::BLK_W;
    localparam int WW  = salwc_pkg::cnt_w(MAX_WAYS);
    localparam int SCW = salwc_pkg::cnt_w(MAX_SETS);
    localparam int SW  = salwc_pkg::idx_w(MAX_SETS);
    localparam int STW = $clog2(BW);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [STW-1:0] cnt_reg,  cnt_next;
    logic [BW-1:0]  dvd_reg,  dvd_next;
    logic [WW-1:0]  rem_reg,  rem_next;
    logic [SCW-1:0] mod_reg,  mod_next;

    logic [WW:0]    rem_sh;
    logic [SCW:0]   mod_sh;
    logic           qbit;

    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[BW-1]};
        qbit      = (rem_sh >= {1'b0, ways});
        mod_sh    = {mod_reg, qbit};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        mod_next  = mod_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = block_id;
            rem_next  = '0;
            mod_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[BW-2:0], 1'b0};
            rem_next = qbit ? WW'(rem_sh - {1'b0, ways}) : WW'(rem_sh);
            // running remainder of the quotient, kept below sets
            mod_next = (mod_sh >= {1'b0, sets}) ? SCW'(mod_sh - {1'b0, sets})
                                                : SCW'(mod_sh);
            cnt_next = cnt_reg + STW'(1);
            if (cnt_reg == STW'(BW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        mod_reg <= mod_next;
    end

    assign done    = done_reg;
    assign set_idx = SW'(mod_reg);

endmodule

[hdl/salwc_way.sv]
// Per-set lookup and LRU update: tag compare in every way, victim and free
// way pick, new tag and meta rows. Combinational. Depends on salwc_pkg.
module salwc_way #(
    parameter int MAX_WAYS = salwc_pkg::DEF_MAX_WAYS
) (
    input  logic [MAX_WAYS*salwc_pkg::BLK_W-1:0]   tag_row,
    input  logic [salwc_pkg::meta_w(MAX_WAYS)-1:0] meta_row,
    input  logic [salwc_pkg::BLK_W-1:0]            blk,
    input  logic                                   wr,
    input  logic [salwc_pkg::cnt_w(MAX_WAYS)-1:0]  ways,
    output logic [MAX_WAYS*salwc_pkg::BLK_W-1:0]   tag_row_new,
    output logic [salwc_pkg::meta_w(MAX_WAYS)-1:0] meta_row_new,
    output salwc_pkg::upd_t                        upd
);

    localparam int BW = salwc_pkg::BLK_W;
    localparam int AW = salwc_pkg::idx_w(MAX_WAYS);
    localparam int CW = salwc_pkg::cnt_w(MAX_WAYS);
    localparam int EW = 2 + AW;
    localparam int MW = salwc_pkg::meta_w(MAX_WAYS);

    logic [MAX_WAYS-1:0] vld;
    logic [MAX_WAYS-1:0] drt;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] vic_vec;
    logic [AW-1:0]       age [MAX_WAYS];
    logic [BW-1:0]       tag [MAX_WAYS];
    logic [CW-1:0]       fill;
    logic [CW-1:0]       fill_m1;
    logic                hit;
    logic                full;
    logic [AW-1:0]       hit_way;
    logic [AW-1:0]       free_way;
    logic [AW-1:0]       vic_way;
    logic [AW-1:0]       slot;
    logic [AW-1:0]       ref_age;

    always_comb
    begin
        fill    = meta_row[MW-1 -: CW];
        fill_m1 = fill - CW'(1);
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            vld[w]     = meta_row[w*EW + AW + 1];
            drt[w]     = meta_row[w*EW + AW];
            age[w]     = meta_row[w*EW +: AW];
            tag[w]     = tag_row[w*BW +: BW];
            hit_vec[w] = vld[w] && (tag[w] == blk);
            // ranks of a set run 0..fill-1, so the LRU line holds fill-1
            vic_vec[w] = vld[w] && (CW'(age[w]) == fill_m1);
        end

        hit_way  = '0;
        free_way = '0;
        vic_way  = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = AW'(w);
            end
            if (!vld[w])
            begin
                free_way = AW'(w);
            end
            if (vic_vec[w])
            begin
                vic_way = AW'(w);
            end
        end

        hit     = |hit_vec;
        full    = (fill >= ways);
        slot    = hit ? hit_way : (full ? vic_way : free_way);
        ref_age = age[slot];

        tag_row_new  = tag_row;
        meta_row_new = meta_row;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (AW'(w) == slot)
            begin
                tag_row_new[w*BW +: BW]   = blk;
                meta_row_new[w*EW + AW + 1] = 1'b1;
                meta_row_new[w*EW + AW]   = hit ? (drt[w] | wr) : wr;
                meta_row_new[w*EW +: AW]  = '0;
            end
            else if (vld[w] && ((!hit && !full) || (age[w] < ref_age)))
            begin
                meta_row_new[w*EW +: AW] = age[w] + AW'(1);
            end
        end
        if (!hit && !full)
        begin
            meta_row_new[MW-1 -: CW] = fill + CW'(1);
        end

        upd.hit      = hit;
        upd.wb       = !hit && full && drt[vic_way];
        upd.wb_block = tag[vic_way];
    end

endmodule

[hdl/set_assoc_lru_writeback_cache.sv]
// Top level of the set-associative LRU write-back cache tag store.
// Depends on salwc_pkg, salwc_ram, salwc_set_idx and salwc_way.
//
//  port group   dir  handshake             beat contents
//  ----------   ---  --------------------  -------------------------------
//  input        in   in_valid / in_ready   action, block_id
//  output       out  out_valid / out_ready mem_op, mem_block, last_of_run
//  config       in   APB psel/penable      ways_in_use @0x0, sets_in_use @0x4
//
//  An access runs through the bit-serial set index divider, the registered set
//  read, the update of both RAMs that queues results, and a return to idle to
//  take the next beat.
//  After reset the meta RAM is cleared one set per cycle, all MAX_SETS sets,
//  with in_ready low; config writes are taken meanwhile.
//  Results (up to two per access) wait in a two-beat output queue; the next
//  access is accepted while they drain and stalls only at its update step.
module set_assoc_lru_writeback_cache #(
    parameter int MAX_SETS = salwc_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS = salwc_pkg::DEF_MAX_WAYS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [salwc_pkg::APB_AW-1:0]    paddr,
    input  logic [salwc_pkg::APB_DW-1:0]    pwdata,
    output logic [salwc_pkg::APB_DW-1:0]    prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic [salwc_pkg::BLK_W-1:0]     block_id,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            mem_op,
    output logic [salwc_pkg::BLK_W-1:0]     mem_block,
    output logic                            last_of_run
);

    localparam int BW    = salwc_pkg::BLK_W;
    localparam int SW    = salwc_pkg::idx_w(MAX_SETS);
    localparam int WCW   = salwc_pkg::cnt_w(MAX_WAYS);
    localparam int SCW   = salwc_pkg::cnt_w(MAX_SETS);
    localparam int MW    = salwc_pkg::meta_w(MAX_WAYS);
    localparam int TW    = MAX_WAYS * BW;
    localparam int WRW   = salwc_pkg::WAYS_REG_W;
    localparam int SRW   = salwc_pkg::SETS_REG_W;
    localparam int DW    = salwc_pkg::APB_DW;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_UPD   = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [SW-1:0]    clr_reg,   clr_next;
    logic [WRW-1:0]   ways_reg,  ways_next;
    logic [SRW-1:0]   sets_reg,  sets_next;
    logic             act_reg,   act_next;
    logic [BW-1:0]    blk_reg,   blk_next;
    logic [SW-1:0]    set_reg,   set_next;
    logic [1:0]       qcnt_reg,  qcnt_next;
    logic             q_op_reg   [2];
    logic             q_op_next  [2];
    logic [BW-1:0]    q_blk_reg  [2];
    logic [BW-1:0]    q_blk_next [2];
    logic             q_last_reg [2];
    logic             q_last_next[2];

    logic [WCW-1:0]   ways_eff;
    logic [SCW-1:0]   sets_eff;
    logic             cfg_we;
    logic             accept;
    logic             commit;
    logic             pop;
    logic             div_done;
    logic [SW-1:0]    div_set;

    logic             meta_we;
    logic [SW-1:0]    meta_waddr;
    logic [MW-1:0]    meta_wdata;
    logic [MW-1:0]    meta_rdata;
    logic [MW-1:0]    meta_new;
    logic             rd_en;
    logic [TW-1:0]    tag_rdata;
    logic [TW-1:0]    tag_new;
    salwc_pkg::upd_t  upd;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        if (paddr[2] == salwc_pkg::REG_SETS)
        begin
            prdata = DW'(sets_reg);
        end
        else
        begin
            prdata = DW'(ways_reg);
        end
    end

    always_comb
    begin
        ways_next = ways_reg;
        sets_next = sets_reg;
        if (cfg_we)
        begin
            if (paddr[2] == salwc_pkg::REG_WAYS)
            begin
                ways_next = pwdata[WRW-1:0];
            end
            else
            begin
                sets_next = pwdata[SRW-1:0];
            end
        end
    end

    // zero acts as one, values above the maximum act as the maximum
    always_comb
    begin
        if (ways_reg == '0)
        begin
            ways_eff = WCW'(1);
        end
        else if (int'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = WCW'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WCW'(ways_reg);
        end

        if (sets_reg == '0)
        begin
            sets_eff = SCW'(1);
        end
        else if (int'(sets_reg) > MAX_SETS)
        begin
            sets_eff = SCW'(MAX_SETS);
        end
        else
        begin
            sets_eff = SCW'(sets_reg);
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == ST_UPD) && (qcnt_reg == 2'd0);
    assign out_valid   = (qcnt_reg != 2'd0);
    assign pop         = out_valid && out_ready;
    assign mem_op      = q_op_reg[0];
    assign mem_block   = q_blk_reg[0];
    assign last_of_run = q_last_reg[0];

    assign rd_en = (state_reg == ST_DIV) && div_done;

    salwc_set_idx #(
        .MAX_WAYS (MAX_WAYS),
        .MAX_SETS (MAX_SETS)
    ) u_set_idx (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .block_id (block_id),
        .ways     (ways_eff),
        .sets     (sets_eff),
        .done     (div_done),
        .set_idx  (div_set)
    );

    salwc_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (commit),
        .waddr (set_reg),
        .wdata (tag_new),
        .re    (rd_en),
        .raddr (div_set),
        .rdata (tag_rdata)
    );

    salwc_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_SETS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (rd_en),
        .raddr (div_set),
        .rdata (meta_rdata)
    );

    salwc_way #(
        .MAX_WAYS (MAX_WAYS)
    ) u_way (
        .tag_row      (tag_rdata),
        .meta_row     (meta_rdata),
        .blk          (blk_reg),
        .wr           (act_reg),
        .ways         (ways_eff),
        .tag_row_new  (tag_new),
        .meta_row_new (meta_new),
        .upd          (upd)
    );

    // meta write port: clearing pass after reset, else the update
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            meta_we    = 1'b1;
            meta_waddr = clr_reg;
            meta_wdata = '0;
        end
        else
        begin
            meta_we    = commit;
            meta_waddr = set_reg;
            meta_wdata = meta_new;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        act_next   = act_reg;
        blk_next   = blk_reg;
        set_next   = set_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + SW'(1);
                if (clr_reg == SW'(MAX_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next   = action;
                    blk_next   = block_id;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    set_next   = div_set;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // two-beat output queue, head at index 0
    always_comb
    begin
        qcnt_next = qcnt_reg;
        for (int i = 0; i < 2; i++)
        begin
            q_op_next[i]   = q_op_reg[i];
            q_blk_next[i]  = q_blk_reg[i];
            q_last_next[i] = q_last_reg[i];
        end
        if (commit)
        begin
            if (upd.hit)
            begin
                qcnt_next = 2'd0;
            end
            else if (upd.wb)
            begin
                q_op_next[0]   = salwc_pkg::OP_WB;
                q_blk_next[0]  = upd.wb_block;
                q_last_next[0] = 1'b0;
                q_op_next[1]   = salwc_pkg::OP_LOAD;
                q_blk_next[1]  = blk_reg;
                q_last_next[1] = 1'b1;
                qcnt_next      = 2'd2;
            end
            else
            begin
                q_op_next[0]   = salwc_pkg::OP_LOAD;
                q_blk_next[0]  = blk_reg;
                q_last_next[0] = 1'b1;
                qcnt_next      = 2'd1;
            end
        end
        else if (pop)
        begin
            q_op_next[0]   = q_op_reg[1];
            q_blk_next[0]  = q_blk_reg[1];
            q_last_next[0] = q_last_reg[1];
            qcnt_next      = qcnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ways_reg  <= salwc_pkg::WAYS_RST;
            sets_reg  <= salwc_pkg::SETS_RST;
            qcnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ways_reg  <= ways_next;
            sets_reg  <= sets_next;
            qcnt_reg  <= qcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        blk_reg <= blk_next;
        set_reg <= set_next;
        for (int i = 0; i < 2; i++)
        begin
            q_op_reg[i]   <= q_op_next[i];
            q_blk_reg[i]  <= q_blk_next[i];
            q_last_reg[i] <= q_last_next[i];
        end
    end

endmodule

[tb/salwc_checker.sv]
// Scoreboard for the cache tag store: follows register writes on the APB port,
// predicts the memory requests of every accepted access and checks each output
// beat against them. Depends on salwc_pkg.
module salwc_checker
    import salwc_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              action,
    input  logic [BLK_W-1:0]  block_id,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              mem_op,
    input  logic [BLK_W-1:0]  mem_block,
    input  logic              last_of_run,
    output int                mismatches,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINES = MAX_SETS * MAX_WAYS;

    typedef struct packed {
        logic             op;
        logic [BLK_W-1:0] blk;
        logic             last;
    } mem_req_t;

    logic [BLK_W-1:0]      line_blk  [LINES];
    bit                    line_live [LINES];
    bit                    line_mod  [LINES];
    int unsigned           line_rank [LINES];
    int unsigned           set_lines [MAX_SETS];
    logic [WAYS_REG_W-1:0] ways_reg = WAYS_RST;
    logic [SETS_REG_W-1:0] sets_reg = SETS_RST;
    mem_req_t              pending_reqs[$];
    int                    bad_beats = 0;

    // append one predicted request at the tail
    function automatic void add_req(input mem_req_t req);
        pending_reqs.insert(pending_reqs.size(), req);
    endfunction

    // make one way the most recent; younger live lines age by one
    function automatic void promote(input int unsigned base, input int unsigned way);
        int unsigned rank;
        rank = line_rank[base + way];
        for (int unsigned w = 0; w < MAX_WAYS; w++)
        begin
            if (w != way && line_live[base + w] && line_rank[base + w] < rank)
                line_rank[base + w]++;
        end
        line_rank[base + way] = 0;
    endfunction

    function automatic void predict_access(input logic wr, input logic [BLK_W-1:0] blk);
        int unsigned ways, sets, set, base, slot, oldest;
        ways = (ways_reg == 0) ? 1 : (ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg;
        sets = (sets_reg == 0) ? 1 : (sets_reg > MAX_SETS) ? MAX_SETS : sets_reg;
        set = (blk / ways) % sets;
        base = set * MAX_WAYS;

        for (int unsigned w = 0; w < MAX_WAYS; w++)
        begin
            if (line_live[base + w] && line_blk[base + w] == blk)
            begin
                promote(base, w);
                if (wr)
                    line_mod[base + w] = 1'b1;
                return;
            end
        end

        slot = MAX_WAYS;
        if (set_lines[set] < ways)
        begin
            for (int unsigned w = 0; w < MAX_WAYS; w++)
            begin
                if (!line_live[base + w] && slot == MAX_WAYS)
                    slot = w;
            end
            if (slot == MAX_WAYS)
                return;
            for (int unsigned w = 0; w < MAX_WAYS; w++)
            begin
                if (line_live[base + w])
                    line_rank[base + w]++;
            end
            set_lines[set]++;
        end
        else
        begin
            // set full (possibly over-full after a way count change): evict LRU
            oldest = 0;
            for (int unsigned w = 0; w < MAX_WAYS; w++)
            begin
                if (line_live[base + w] && (slot == MAX_WAYS || line_rank[base + w] > oldest))
                begin
                    slot = w;
                    oldest = line_rank[base + w];
                end
            end
            if (slot == MAX_WAYS)
                return;
            if (line_mod[base + slot])
                add_req({OP_WB, line_blk[base + slot], 1'b0});
            promote(base, slot);
        end

        line_live[base + slot] = 1'b1;
        line_blk[base + slot] = blk;
        line_mod[base + slot] = wr;
        line_rank[base + slot] = 0;
        add_req({OP_LOAD, blk, 1'b1});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mem_req_t want;
        if (!rst_n)
        begin
            foreach (line_live[i])
            begin
                line_live[i] = 1'b0;
                line_mod[i] = 1'b0;
                line_rank[i] = 0;
            end
            foreach (set_lines[i])
                set_lines[i] = 0;
            ways_reg = WAYS_RST;
            sets_reg = SETS_RST;
            pending_reqs.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_WAYS)
                    ways_reg = pwdata[WAYS_REG_W-1:0];
                else
                    sets_reg = pwdata[SETS_REG_W-1:0];
            end

            if (out_valid && out_ready)
            begin
                if (pending_reqs.size() == 0)
                begin
                    bad_beats++;
                    $display("%0t: beat expected none actual op=%0b block=%h last=%0b",
                             $time, mem_op, mem_block, last_of_run);
                end
                else
                begin
                    want = pending_reqs.pop_front();
                    if (want !== {mem_op, mem_block, last_of_run})
                    begin
                        bad_beats++;
                        if (want.op !== mem_op)
                            $display("%0t: mem_op expected %0b actual %0b",
                                     $time, want.op, mem_op);
                        if (want.blk !== mem_block)
                            $display("%0t: mem_block expected %h actual %h",
                                     $time, want.blk, mem_block);
                        if (want.last !== last_of_run)
                            $display("%0t: last_of_run expected %0b actual %0b",
                                     $time, want.last, last_of_run);
                    end
                end
            end

            if (in_valid && in_ready)
                predict_access(action, block_id);

            outstanding <= pending_reqs.size();
        end
        mismatches <= bad_beats;
    end

endmodule

[tb/tb.sv]
// Testbench top for set_assoc_lru_writeback_cache: clock, reset, register
// writes, access stimulus and output back-pressure. Checking is done by
// salwc_checker. Depends on salwc_pkg, salwc_checker and the cache RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import salwc_pkg::*;

    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 95;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_PHASE   = 5;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              action = ACT_READ;
    logic [BLK_W-1:0]  block_id = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              mem_op;
    logic [BLK_W-1:0]  mem_block;
    logic              last_of_run;
    int                mismatches;
    int                outstanding;
    bit                calm = 1'b0;

    set_assoc_lru_writeback_cache dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .block_id    (block_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mem_op      (mem_op),
        .mem_block   (mem_block),
        .last_of_run (last_of_run)
    );

    salwc_checker req_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .block_id    (block_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mem_op      (mem_op),
        .mem_block   (mem_block),
        .last_of_run (last_of_run),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("set_assoc_lru_writeback_cache test failed");
        $finish;
    end

    // setup cycle, access cycle; the register takes the value at the edge that ends the access cycle
    task automatic write_reg(input logic sel, input logic [APB_DW-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // valid stays high straight into the next beat unless a gap follows or stop is set
    task automatic send_access(input logic act, input logic [BLK_W-1:0] blk, input bit stop);
        int gap;
        in_valid <= 1'b1;
        action <= act;
        block_id <= blk;
        do @(posedge clk); while (!in_ready);
        gap = 0;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 19)
                gap++;
        end
        if (gap > 0 || stop)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // all requests back, then time for a trailing hit to finish inside the block
    task automatic settle();
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int ways_pick[4];
        int sets_pick[4];
        int ways_val, sets_val, eff_w, eff_s, roll;
        logic [BLK_W-1:0] base, blk;
        logic act;

        ways_pick = '{1, 8, 15, 0};
        sets_pick = '{64, 1, 127, 0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // two ways, one set: fill, hits, dirty and clean evictions
        write_reg(REG_WAYS, 2);
        write_reg(REG_SETS, 1);
        send_access(ACT_READ, 32'h0000_0000, 1'b0);
        send_access(ACT_WRITE, 32'hFFFF_FFFF, 1'b0);
        send_access(ACT_READ, 32'h0000_0000, 1'b0);
        send_access(ACT_READ, 32'h0000_0005, 1'b0);
        send_access(ACT_WRITE, 32'h0000_0000, 1'b0);
        send_access(ACT_READ, 32'h0000_0007, 1'b0);
        send_access(ACT_READ, 32'h0000_0009, 1'b0);
        send_access(ACT_WRITE, 32'h0000_0007, 1'b1);
        settle();

        // more ways mid-run: the set has room again
        write_reg(REG_WAYS, 4);
        send_access(ACT_READ, 32'h0000_000B, 1'b0);
        send_access(ACT_WRITE, 32'h0000_000D, 1'b1);
        settle();

        // zero ways and zero sets act as one; the over-full set evicts one per miss
        write_reg(REG_WAYS, 0);
        write_reg(REG_SETS, 0);
        send_access(ACT_READ, 32'h0000_0064, 1'b0);
        send_access(ACT_WRITE, 32'h0000_0065, 1'b0);
        send_access(ACT_READ, 32'h0000_0064, 1'b1);
        settle();

        // counts above the maximum clamp
        write_reg(REG_WAYS, 15);
        write_reg(REG_SETS, 127);
        send_access(ACT_READ, 32'h8000_0000, 1'b0);
        send_access(ACT_WRITE, 32'h7FFF_FFFF, 1'b0);
        send_access(ACT_READ, 32'h1234_5678, 1'b0);
        send_access(ACT_WRITE, 32'h0000_0000, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            ways_val = (p < 4) ? ways_pick[p] : $urandom_range(0, 15);
            sets_val = (p < 4) ? sets_pick[p] : $urandom_range(0, 127);
            write_reg(REG_WAYS, ways_val);
            write_reg(REG_SETS, sets_val);
            calm <= (p == CALM_PHASE);
            eff_w = (ways_val == 0) ? 1 : (ways_val > DEF_MAX_WAYS) ? DEF_MAX_WAYS : ways_val;
            eff_s = (sets_val == 0) ? 1 : (sets_val > DEF_MAX_SETS) ? DEF_MAX_SETS : sets_val;
            base = $urandom();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // mostly a narrow window for reuse, some wider conflicts, some noise
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    blk = base + $urandom_range(0, 3 * eff_w - 1);
                else if (roll < 85)
                    blk = base + $urandom_range(0, 4 * eff_w * eff_s - 1);
                else
                    blk = $urandom();
                act = ($urandom_range(0, 99) < 40) ? ACT_WRITE : ACT_READ;
                send_access(act, blk, i == PHASE_ITEMS - 1);
            end
        end

        settle();
        if (mismatches == 0)
            $display("set_assoc_lru_writeback_cache test passed");
        else
            $display("set_assoc_lru_writeback_cache test failed");
        $finish;
    end

    // output side: random stalls, one long hold-off to back the block up
    initial
    begin
        int beats;
        int hold;
        bit held;
        beats = 0;
        hold = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                beats++;
            if (!held && beats >= HOLD_AFTER)
            begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 19);
        end
    end

endmodule
